[rtl/core/ihex_pkg.sv]
`default_nettype none

package ihex_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } ihex_char_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] record_address;
        logic [7:0]  byte_index;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
    } ihex_result_t;

    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_RECORD = 3'd1;
    localparam logic [2:0] KIND_EOF    = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    localparam logic [1:0] ERR_COLON  = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_TYPE   = 2'd2;
    localparam logic [1:0] ERR_HEX    = 2'd3;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;

    localparam logic [9:0] HEADER_END = 10'd9;

    // result queue: power of two, at least 4
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef logic [RQ_AW-1:0] rq_ptr_t;
    typedef logic [RQ_AW:0]   rq_count_t;

    // room for the two results of one request
    localparam rq_count_t RQ_STALL_AT = rq_count_t'(RQ_DEPTH - 2);

    // {ok, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic ihex_result_t make_result(input logic [2:0] kind,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] data,
                                                 input logic [1:0] err);
        ihex_result_t r;
        r.result_kind    = kind;
        r.record_address = addr;
        r.byte_index     = idx;
        r.data_byte      = data;
        r.error_code     = err;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/intel_hex_record_parser_top.sv]
`default_nettype none

// Intel HEX text parser. One character request is taken per clock while
// char_stall is low; each request is decoded in the cycle it is accepted
// and its results (at most two, and two only for end of input after a
// pending line) go into a 4-entry result queue that drains one result per
// clock while result_stall is low, so from an empty queue the first result
// is visible the cycle after its request. char_stall rises while the queue
// holds more than two results, which is what limits the rate when the
// result side stalls. After an end-of-file record, end of input or a fatal
// error, further requests are taken and produce nothing until reset.
module intel_hex_record_parser_top
    import ihex_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         char_valid,
    output logic              char_stall,
    input  wire ihex_char_t   char_req,
    output logic              result_valid,
    input  wire logic         result_stall,
    output ihex_result_t      result_req
);

    logic [9:0]  pos_reg,    pos_next;
    logic [7:0]  count_reg,  count_next;
    logic [15:0] addr_reg,   addr_next;
    logic [3:0]  nib_reg,    nib_next;
    logic        fin_reg,    fin_next;
    logic        fail_reg,   fail_next;

    ihex_result_t q_mem [RQ_DEPTH];
    rq_ptr_t      wr_ptr_reg;
    rq_ptr_t      rd_ptr_reg;
    rq_count_t    q_count_reg;

    logic         accept;
    logic         pop;
    logic [1:0]   push_cnt;
    ihex_result_t r0;
    ihex_result_t r1;
    logic         do_end;
    logic [4:0]   hex;
    logic [7:0]   kind_val;
    logic [9:0]   line_len;
    logic [9:0]   limit;
    logic [9:0]   rel;

    assign char_stall   = (q_count_reg > RQ_STALL_AT);
    assign accept       = char_valid && !char_stall;
    assign result_valid = (q_count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign result_req   = q_mem[rd_ptr_reg];

    assign hex      = hex_nibble(char_req.char_code);
    assign kind_val = {nib_reg, hex[3:0]};
    assign line_len = (10'(count_reg) << 1) + HEADER_END + 10'd2;
    assign limit    = (10'(count_reg) << 1) + HEADER_END;
    assign rel      = pos_reg - HEADER_END;

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        nib_next   = nib_reg;
        fin_next   = fin_reg;
        fail_next  = fail_reg;
        push_cnt   = 2'd0;
        r0         = '0;
        r1         = '0;
        do_end     = 1'b0;

        if (!fin_reg && !fail_reg) begin
            if (char_req.end_of_input) begin
                if (pos_reg != 10'd0) begin
                    do_end = 1'b1;
                end else begin
                    r0       = make_result(KIND_DONE, 16'd0, 8'd0, 8'd0, ERR_COLON);
                    push_cnt = 2'd1;
                    fin_next = 1'b1;
                end
            end else if (char_req.char_code == CHAR_LF) begin
                do_end = 1'b1;
            end else if (pos_reg == 10'd0) begin
                if (char_req.char_code != CHAR_COLON) begin
                    r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_COLON);
                    push_cnt  = 2'd1;
                    fail_next = 1'b1;
                end else begin
                    pos_next = 10'd1;
                end
            end else if (pos_reg < HEADER_END) begin
                if (!hex[4]) begin
                    r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_HEX);
                    push_cnt  = 2'd1;
                    fail_next = 1'b1;
                end else begin
                    pos_next = pos_reg + 10'd1;
                    priority if (pos_reg == 10'd1 || pos_reg == 10'd7) begin
                        nib_next = hex[3:0];
                    end else if (pos_reg == 10'd2) begin
                        count_next = {nib_reg, hex[3:0]};
                    end else if (pos_reg == 10'd3) begin
                        addr_next = {12'd0, hex[3:0]};
                    end else if (pos_reg <= 10'd6) begin
                        addr_next = {addr_reg[11:0], hex[3:0]};
                    end else begin
                        if (kind_val == TYPE_EOF) begin
                            r0       = make_result(KIND_EOF, addr_reg, 8'd0, 8'd0,
                                                   ERR_COLON);
                            push_cnt = 2'd1;
                            fin_next = 1'b1;
                        end else if (kind_val != TYPE_DATA) begin
                            r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0,
                                                    ERR_TYPE);
                            push_cnt  = 2'd1;
                            fail_next = 1'b1;
                        end
                    end
                end
            end else begin
                if (pos_reg < limit) begin
                    if (!hex[4]) begin
                        r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_HEX);
                        push_cnt  = 2'd1;
                        fail_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + 10'd1;
                        if (!rel[0]) begin
                            nib_next = hex[3:0];
                        end else begin
                            r0       = make_result(KIND_DATA, addr_reg, rel[8:1],
                                                   {nib_reg, hex[3:0]}, ERR_COLON);
                            push_cnt = 2'd1;
                        end
                    end
                end else if (pos_reg >= limit + 10'd2) begin
                    r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_LENGTH);
                    push_cnt  = 2'd1;
                    fail_next = 1'b1;
                end else begin
                    pos_next = pos_reg + 10'd1;
                end
            end
        end

        if (do_end) begin
            push_cnt = 2'd1;
            priority if (pos_reg == 10'd0) begin
                r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_COLON);
                fail_next = 1'b1;
            end else if (pos_reg < HEADER_END || pos_reg != line_len) begin
                r0        = make_result(KIND_ERROR, addr_reg, 8'd0, 8'd0, ERR_LENGTH);
                fail_next = 1'b1;
            end else begin
                r0       = make_result(KIND_RECORD, addr_reg, 8'd0, 8'd0, ERR_COLON);
                pos_next = 10'd0;
                if (char_req.end_of_input) begin
                    r1       = make_result(KIND_DONE, 16'd0, 8'd0, 8'd0, ERR_COLON);
                    push_cnt = 2'd2;
                    fin_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= '0;
            count_reg   <= '0;
            addr_reg    <= '0;
            nib_reg     <= '0;
            fin_reg     <= 1'b0;
            fail_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            if (accept) begin
                pos_reg    <= pos_next;
                count_reg  <= count_next;
                addr_reg   <= addr_next;
                nib_reg    <= nib_next;
                fin_reg    <= fin_next;
                fail_reg   <= fail_next;
                wr_ptr_reg <= wr_ptr_reg + rq_ptr_t'(push_cnt);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rq_ptr_t'(1);
            end
            q_count_reg <= q_count_reg + rq_count_t'(accept ? push_cnt : 2'd0)
                           - rq_count_t'(pop ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && push_cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= r0;
        end
        if (accept && push_cnt == 2'd2) begin
            q_mem[wr_ptr_reg + rq_ptr_t'(1)] <= r1;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= rq_count_t'(RQ_DEPTH))
        else $error("result queue overflow");

    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (fin_reg || fail_reg)) |=> q_count_reg <= $past(q_count_reg))
        else $error("request after end produced a result");

    a_pair_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push_cnt == 2'd2) |=> fin_reg)
        else $error("two results without finishing");

    a_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(fin_reg && fail_reg))
        else $error("finished and failed both set");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_intel_hex_record_parser_top.sv]
module tb_intel_hex_record_parser_top;
    import ihex_pkg::*;

    localparam int unsigned RANDOM_CHARS = 1100;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 20;

    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UF = "F";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LF = "f";

    typedef struct {
        string        text;
        logic         finish_input;
        logic         has_typed;
        ihex_result_t typed;
    } hex_text_t;

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_stall;
    ihex_char_t   char_req;
    logic         result_valid;
    logic         result_stall;
    ihex_result_t result_req;

    // parser state mirror
    logic [9:0]  line_pos;
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [3:0]  nibble_hi;
    logic        parse_done;
    logic        parse_failed;

    ihex_result_t parser_results_due[$];
    logic [7:0]   text_buf[$];
    hex_text_t    opening_lines[$];
    hex_text_t    closing_lines[$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_results;

    intel_hex_record_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_req     (char_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_req   (result_req)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic decode_digit(input logic [7:0] ch, output logic [3:0] val);
        val = '0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            val = 4'(ch - CH_0);
            return 1'b1;
        end
        if (ch >= CH_UA && ch <= CH_UF)
        begin
            val = 4'(ch - CH_UA + 8'd10);
            return 1'b1;
        end
        if (ch >= CH_LA && ch <= CH_LF)
        begin
            val = 4'(ch - CH_LA + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] v);
        if (v < 4'd10)
            return CH_0 + 8'(v);
        if ($urandom_range(0, 1) == 0)
            return CH_UA + 8'(v) - 8'd10;
        return CH_LA + 8'(v) - 8'd10;
    endfunction

    task automatic queue_result(input logic [2:0] kind, input logic [15:0] addr,
                                input logic [7:0] idx, input logic [7:0] data,
                                input logic [1:0] err);
        ihex_result_t r;
        r.result_kind    = kind;
        r.record_address = addr;
        r.byte_index     = idx;
        r.data_byte      = data;
        r.error_code     = err;
        parser_results_due.push_back(r);
    endtask

    task automatic raise_error(input logic [1:0] err);
        parse_failed = 1'b1;
        queue_result(KIND_ERROR, rec_addr, '0, '0, err);
    endtask

    task automatic close_line();
        logic [10:0] line_len;
        line_len = 11'(HEADER_END) + 11'd2 + {2'b0, rec_count, 1'b0};
        if (line_pos == '0)
            raise_error(ERR_COLON);
        else if (line_pos < HEADER_END)
            raise_error(ERR_LENGTH);
        else if ({1'b0, line_pos} != line_len)
            raise_error(ERR_LENGTH);
        else
        begin
            queue_result(KIND_RECORD, rec_addr, '0, '0, '0);
            line_pos = '0;
        end
    endtask

    task automatic parse_char(input ihex_char_t item);
        logic        is_hex;
        logic [3:0]  v;
        logic [10:0] data_end;
        logic [9:0]  rel;
        if (parse_done || parse_failed)
            return;
        if (item.end_of_input)
        begin
            if (line_pos != '0)
            begin
                close_line();
                if (parse_failed)
                    return;
            end
            parse_done = 1'b1;
            queue_result(KIND_DONE, '0, '0, '0, '0);
            return;
        end
        if (item.char_code == CHAR_LF)
        begin
            close_line();
            return;
        end
        if (line_pos == '0)
        begin
            if (item.char_code != CHAR_COLON)
                raise_error(ERR_COLON);
            else
                line_pos = 10'd1;
            return;
        end
        is_hex = decode_digit(item.char_code, v);
        if (line_pos < HEADER_END)
        begin
            if (!is_hex)
            begin
                raise_error(ERR_HEX);
                return;
            end
            case (line_pos)
                10'd1, 10'd7: nibble_hi = v;
                10'd2:        rec_count = {nibble_hi, v};
                10'd3:        rec_addr = {12'd0, v};
                10'd4, 10'd5, 10'd6: rec_addr = {rec_addr[11:0], v};
                default:
                begin
                    rec_type = {nibble_hi, v};
                    if (rec_type == TYPE_EOF)
                    begin
                        parse_done = 1'b1;
                        queue_result(KIND_EOF, rec_addr, '0, '0, '0);
                        return;
                    end
                    if (rec_type != TYPE_DATA)
                    begin
                        raise_error(ERR_TYPE);
                        return;
                    end
                end
            endcase
            line_pos = line_pos + 10'd1;
            return;
        end
        data_end = 11'(HEADER_END) + {2'b0, rec_count, 1'b0};
        if ({1'b0, line_pos} < data_end)
        begin
            if (!is_hex)
            begin
                raise_error(ERR_HEX);
                return;
            end
            rel = line_pos - HEADER_END;
            if (!rel[0])
                nibble_hi = v;
            else
                queue_result(KIND_DATA, rec_addr, rel[8:1], {nibble_hi, v}, '0);
        end
        else if ({1'b0, line_pos} >= data_end + 11'd2)
        begin
            raise_error(ERR_LENGTH);
            return;
        end
        line_pos = line_pos + 10'd1;
    endtask

    task automatic send_char(input ihex_char_t item, input logic has_typed,
                             input ihex_result_t typed);
        int unsigned gap;
        int unsigned due_before;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_req   <= item;
        do @(posedge clk); while (char_stall);
        due_before = parser_results_due.size();
        parse_char(item);
        if (has_typed)
        begin
            if (parser_results_due.size() > due_before)
                void'(parser_results_due.pop_back());
            parser_results_due.push_back(typed);
        end
        items_sent++;
    endtask

    task automatic send_text(input logic finish_input, input logic has_typed,
                             input ihex_result_t typed);
        ihex_char_t item;
        while (text_buf.size() != 0)
        begin
            item.char_code    = text_buf.pop_front();
            item.end_of_input = 1'b0;
            send_char(item, has_typed && !finish_input && text_buf.size() == 0, typed);
        end
        if (finish_input)
        begin
            item.char_code    = 8'($urandom);
            item.end_of_input = 1'b1;
            send_char(item, has_typed, typed);
        end
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic append_hex(input logic [7:0] b);
        text_buf.push_back(digit_char(b[7:4]));
        text_buf.push_back(digit_char(b[3:0]));
    endtask

    task automatic build_data_line(input logic [7:0] count);
        logic [15:0] addr;
        logic [7:0]  ch;
        addr = 16'($urandom);
        text_buf.push_back(CHAR_COLON);
        append_hex(count);
        append_hex(addr[15:8]);
        append_hex(addr[7:0]);
        append_hex(TYPE_DATA);
        repeat (count) append_hex(8'($urandom));
        // checksum: any character but a line feed
        repeat (2)
        begin
            do ch = 8'($urandom); while (ch == CHAR_LF);
            text_buf.push_back(ch);
        end
        text_buf.push_back(CHAR_LF);
    endtask

    task automatic wait_results_drained();
        char_valid <= 1'b0;
        do @(posedge clk); while (parser_results_due.size() != 0);
    endtask

    task automatic add_line(ref hex_text_t table_q[$], input string text,
                            input logic finish_input, input logic has_typed,
                            input logic [2:0] kind, input logic [15:0] addr,
                            input logic [1:0] err);
        hex_text_t row;
        row.text                 = text;
        row.finish_input         = finish_input;
        row.has_typed            = has_typed;
        row.typed.result_kind    = kind;
        row.typed.record_address = addr;
        row.typed.byte_index     = '0;
        row.typed.data_byte      = '0;
        row.typed.error_code     = err;
        table_q.push_back(row);
    endtask

    // result side: random stall, plus one long hold on request
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        ihex_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (parser_results_due.size() == 0)
            begin
                $error("result with nothing due: kind %0d addr %h",
                       result_req.result_kind, result_req.record_address);
                error_count++;
            end
            else
            begin
                want = parser_results_due.pop_front();
                if (result_req.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, result_req.result_kind);
                    error_count++;
                end
                if (result_req.record_address !== want.record_address)
                begin
                    $error("record_address: expected %h, got %h",
                           want.record_address, result_req.record_address);
                    error_count++;
                end
                if (result_req.byte_index !== want.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d",
                           want.byte_index, result_req.byte_index);
                    error_count++;
                end
                if (result_req.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %h, got %h",
                           want.data_byte, result_req.data_byte);
                    error_count++;
                end
                if (result_req.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, result_req.error_code);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[intel_hex_record_parser_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        ihex_char_t   item;
        ihex_result_t no_typed;
        hex_text_t    row;
        int unsigned  line_no;
        logic [7:0]   count;

        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_req   <= '0;

        line_pos       = '0;
        rec_count      = '0;
        rec_addr       = '0;
        rec_type       = '0;
        nibble_hi      = '0;
        parse_done     = 1'b0;
        parse_failed   = 1'b0;
        error_count    = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_results   = 1'b0;
        no_typed       = '0;

        add_line(opening_lines, ":00000000FF\n", 1'b0, 1'b1, KIND_RECORD, 16'h0000, '0);
        add_line(opening_lines, ":01FFFF00aB~!\n", 1'b0, 1'b1, KIND_RECORD, 16'hFFFF, '0);

        // each ends the parse, so one per run
        add_line(closing_lines, ":00ABCD00FF\n\n", 1'b0, 1'b1, KIND_ERROR, 16'hABCD,
                 ERR_COLON);
        add_line(closing_lines, ":00abcd00FF\nX", 1'b0, 1'b1, KIND_ERROR, 16'hABCD,
                 ERR_COLON);
        add_line(closing_lines, ":00AB\n", 1'b0, 1'b1, KIND_ERROR, 16'h00AB, ERR_LENGTH);
        add_line(closing_lines, ":00ABCD0G", 1'b0, 1'b1, KIND_ERROR, 16'hABCD, ERR_HEX);
        add_line(closing_lines, ":00AbCd02", 1'b0, 1'b1, KIND_ERROR, 16'hABCD, ERR_TYPE);
        add_line(closing_lines, ":02ABCD0012Z", 1'b0, 1'b1, KIND_ERROR, 16'hABCD, ERR_HEX);
        add_line(closing_lines, ":00ABCD00FFF", 1'b0, 1'b1, KIND_ERROR, 16'hABCD,
                 ERR_LENGTH);
        add_line(closing_lines, ":00ABCD00FF\r", 1'b0, 1'b1, KIND_ERROR, 16'hABCD,
                 ERR_LENGTH);
        add_line(closing_lines, ":02ABCD001234\n", 1'b0, 1'b1, KIND_ERROR, 16'hABCD,
                 ERR_LENGTH);
        add_line(closing_lines, ":00ABCD01", 1'b0, 1'b1, KIND_EOF, 16'hABCD, '0);
        add_line(closing_lines, "", 1'b1, 1'b1, KIND_DONE, 16'h0000, '0);
        add_line(closing_lines, ":00ABCD00FF", 1'b1, 1'b1, KIND_DONE, 16'h0000, '0);
        add_line(closing_lines, ":00AB", 1'b1, 1'b1, KIND_ERROR, 16'h00AB, ERR_LENGTH);
        add_line(closing_lines, ":0300100041c2F3X\xFF", 1'b1, 1'b0, KIND_DONE, '0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_lines[i])
        begin
            row = opening_lines[i];
            load_text(row.text);
            send_text(row.finish_input, row.has_typed, row.typed);
        end

        line_no = 0;
        while (items_sent < RANDOM_CHARS)
        begin
            case ((line_no / 5) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (line_no == 10)
            begin
                send_idle_pct = 0;
                hold_results  = 1'b1;
            end
            if (line_no == 16)
                wait_results_drained();

            if (line_no == 20)
                count = 8'hFF;
            else if ($urandom_range(0, 9) == 0)
                count = 8'($urandom_range(8, 40));
            else
                count = 8'($urandom_range(0, 7));
            build_data_line(count);
            send_text(1'b0, 1'b0, no_typed);
            line_no++;
        end

        send_idle_pct  = 8;
        recv_stall_pct = 8;
        row = closing_lines[$urandom_range(0, closing_lines.size() - 1)];
        load_text(row.text);
        send_text(row.finish_input, row.has_typed, row.typed);

        // parse is over; these must produce nothing
        for (int i = 0; i < 6; i++)
        begin
            item.char_code    = 8'($urandom);
            item.end_of_input = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            send_char(item, 1'b0, no_typed);
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[intel_hex_record_parser_top] OK");
        else
            $display("[intel_hex_record_parser_top] ERROR");
        $finish;
    end

endmodule

[intel_hex_record_parser_top.f]
rtl/core/ihex_pkg.sv
rtl/core/intel_hex_record_parser_top.sv
tb/sv/tb_intel_hex_record_parser_top.sv
